### src/emad_pkg.sv
// types and constants shared by the event mask action dispatcher modules
package emad_pkg;

   localparam int MASK_W      = 16;
   localparam int POLICY_W    = 4;
   localparam int USE_W       = 3;
   localparam int EVENT_NUM_W = 4;
   localparam int BIND_W      = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int MASK_REGS   = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_MASK0  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK1  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK2  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MASK3  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_POLICY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_USE = 3'd5;

   localparam logic REQ_TRIGGER = 1'b0;
   localparam logic REQ_LOOP    = 1'b1;

   typedef struct packed {
      logic              trig;
      logic              start;
      logic              test;
      logic [BIND_W-1:0] bind_sel;
      logic              rd;
      logic              load;
   } emad_cmd_type;

   typedef struct packed {
      logic [USE_W-1:0] n_active;
      logic             out_free;
   } emad_stat_type;

endpackage

### src/emad_ctrl.sv
// controller state machine: sequences trigger beats and loop steps
module emad_ctrl
   import emad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic          req_type,
   input  emad_stat_type stat,
   output emad_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_TEST = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_LOAD = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [USE_W-1:0] bind_ff, bind_in;
   logic             accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      bind_in      = bind_ff;
      cmd          = '0;
      cmd.bind_sel = bind_ff[BIND_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_TRIGGER) begin
                  cmd.trig = 1'b1;
               end else begin
                  cmd.start = 1'b1;
                  bind_in   = '0;
                  state_in  = (stat.n_active == '0) ? ST_READ : ST_TEST;
               end
            end
         end
         ST_TEST: begin
            cmd.test = 1'b1;
            bind_in  = USE_W'(bind_ff + 3'd1);
            if (bind_in == stat.n_active) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd   = 1'b1;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         bind_ff  <= '0;
      end else begin
         state_ff <= state_in;
         bind_ff  <= bind_in;
      end
   end

endmodule

### src/emad_dpath.sv
// datapath: registers, pending vector, binding test, action queue and result register
module emad_dpath
   import emad_pkg::*;
#(
   parameter int EVENT_BITS   = 16,
   parameter int NUM_BINDINGS = 4,
   parameter int QUEUE_DEPTH  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic [EVENT_NUM_W-1:0] req_event_number,
   input  emad_cmd_type           cmd,
   output emad_stat_type          stat,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_action_valid,
   output logic [BIND_W-1:0]      rsp_action_binding,
   output logic                   rsp_queue_overflow
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   logic [MASK_W-1:0]     mask_ff [MASK_REGS];
   logic [MASK_W-1:0]     mask_in [MASK_REGS];
   logic [POLICY_W-1:0]   policy_ff, policy_in;
   logic [USE_W-1:0]      use_ff, use_in;
   logic [EVENT_BITS-1:0] pend_ff, pend_in;
   logic [PTR_W-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  out_valid_ff, out_valid_in;
   logic                  out_act_ff, out_act_in;
   logic [BIND_W-1:0]     out_bind_ff, out_bind_in;
   logic                  out_ovf_ff, out_ovf_in;
   logic [BIND_W-1:0]     queue_ff [QUEUE_DEPTH];
   logic [BIND_W-1:0]     queue_rd_ff;
   logic [EVENT_BITS-1:0] mask_ext, hit;
   logic                  fire, push;

   assign mask_ext = EVENT_BITS'(mask_ff[cmd.bind_sel]);
   assign hit      = pend_ff & mask_ext;
   assign fire     = policy_ff[cmd.bind_sel] ? (hit == mask_ext) : (hit != '0);
   assign push     = cmd.test && fire && (count_ff != CNT_FULL);

   assign stat.n_active = (use_ff > USE_W'(NUM_BINDINGS)) ? USE_W'(NUM_BINDINGS) : use_ff;
   assign stat.out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      mask_in      = mask_ff;
      policy_in    = policy_ff;
      use_in       = use_ff;
      pend_in      = pend_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      out_valid_in = out_valid_ff;
      out_act_in   = out_act_ff;
      out_bind_in  = out_bind_ff;
      out_ovf_in   = out_ovf_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_MASK0:  mask_in[0] = csr_data;
            CSR_MASK1:  mask_in[1] = csr_data;
            CSR_MASK2:  mask_in[2] = csr_data;
            CSR_MASK3:  mask_in[3] = csr_data;
            CSR_POLICY: policy_in  = csr_data[POLICY_W-1:0];
            CSR_IN_USE: use_in     = csr_data[USE_W-1:0];
            default:    ;
         endcase
      end

      // events beyond the vector are dropped
      if (cmd.trig && (int'(req_event_number) < EVENT_BITS)) begin
         pend_in = pend_ff | (EVENT_BITS'(1) << req_event_number);
      end

      if (cmd.start) begin
         ovf_in = 1'b0;
      end

      if (cmd.test && fire) begin
         pend_in = pend_ff & ~mask_ext;
         if (push) begin
            tail_in  = (tail_ff == PTR_LAST) ? '0 : PTR_W'(tail_ff + 1'b1);
            count_in = CNT_W'(count_ff + 1'b1);
         end else begin
            ovf_in = 1'b1;
         end
      end

      if (rsp_valid && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (cmd.load) begin
         out_valid_in = 1'b1;
         out_act_in   = (count_ff != '0);
         out_bind_in  = (count_ff != '0) ? queue_rd_ff : '0;
         out_ovf_in   = ovf_ff;
         if (count_ff != '0) begin
            head_in  = (head_ff == PTR_LAST) ? '0 : PTR_W'(head_ff + 1'b1);
            count_in = CNT_W'(count_ff - 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MASK_REGS; i++) begin
            mask_ff[i] <= '0;
         end
         policy_ff    <= '0;
         use_ff       <= '0;
         pend_ff      <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mask_ff      <= mask_in;
         policy_ff    <= policy_in;
         use_ff       <= use_in;
         pend_ff      <= pend_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_act_ff  <= out_act_in;
      out_bind_ff <= out_bind_in;
      out_ovf_ff  <= out_ovf_in;
   end

   // action queue storage, registered read
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[tail_ff] <= cmd.bind_sel;
      end
      if (cmd.rd) begin
         queue_rd_ff <= queue_ff[head_ff];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_action_valid   = out_act_ff;
   assign rsp_action_binding = out_bind_ff;
   assign rsp_queue_overflow = out_ovf_ff;

endmodule

### src/event_mask_action_dispatcher_top.sv
// Event mask action dispatcher: pending events, mask bindings, action queue.
// Request channel (req_*): a trigger beat sets one pending event bit; a loop
// beat tests the active bindings in index order, queues the index of each
// binding that fires and clears the pending bits under its mask, then pops
// one queued index. Response channel (rsp_*): one beat per loop step
// carrying the popped index, whether the queue held one, and whether any
// push of that step was dropped. A trigger gives no response beat.
// A loop step runs from acceptance through the test of each of the n active
// bindings, n being bindings_in_use capped at NUM_BINDINGS, one at a time in
// the shared compare unit, then the queue memory read, then the load of the
// result register. Requests are taken only in the idle state, so steps are
// handled one at a time. The result register parts the two channels:
// a new request is taken while a result waits; a loop step that finishes
// while the receiver stalls holds in its last cycle until the result
// register frees. The user must write configuration (csr_*) only while
// the block is idle; the block does not enforce it. Synchronous reset
// clears configuration, pending events, queue state and overflow flag.
module event_mask_action_dispatcher_top
   import emad_pkg::*;
#(
   parameter int EVENT_BITS   = 16,
   parameter int NUM_BINDINGS = 4,
   parameter int QUEUE_DEPTH  = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_type,
   input  logic [EVENT_NUM_W-1:0] req_event_number,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_action_valid,
   output logic [BIND_W-1:0]      rsp_action_binding,
   output logic                   rsp_queue_overflow
);

   emad_cmd_type  cmd;
   emad_stat_type stat;

   emad_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_type),
      .stat      (stat),
      .cmd       (cmd)
   );

   emad_dpath #(
      .EVENT_BITS   (EVENT_BITS),
      .NUM_BINDINGS (NUM_BINDINGS),
      .QUEUE_DEPTH  (QUEUE_DEPTH)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_event_number   (req_event_number),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_action_valid   (rsp_action_valid),
      .rsp_action_binding (rsp_action_binding),
      .rsp_queue_overflow (rsp_queue_overflow)
   );

endmodule
